[rtl/assert_macros.svh]
// Assertion macros for the scroll edge address generator.
// Expects a clock named aclk and an active-low reset named aresetn in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Check that one condition implies another on the next clock edge.
`define ASSERT_NEXT(label, cond, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (cond) |=> (expr)) else $error(msg);

`endif

[rtl/tsea_pkg.sv]
// Shared types, constants and helpers for the scroll edge address generator.
// No dependencies.
`timescale 1ns / 1ps

package tsea_pkg;

    localparam int SCREEN_TILES_X_DEF = 30;
    localparam int SCREEN_TILES_Y_DEF = 20;

    localparam int CAM_W      = 16;
    localparam int COORD_W    = 10;
    localparam int LOG2_W     = 4;
    localparam int BLOCK_W    = 5;
    localparam int SRC_W      = 20;
    localparam int DST_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    localparam logic [LOG2_W-1:0] LOG2_MIN = 4'd3;
    localparam logic [LOG2_W-1:0] LOG2_MAX = 4'd10;

    localparam logic [LOG2_W-1:0]  WIDTH_LOG2_RST  = 4'd6;
    localparam logic [LOG2_W-1:0]  HEIGHT_LOG2_RST = 4'd9;
    localparam logic [BLOCK_W-1:0] BLOCK_RST       = 5'd0;

    localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH_LOG2  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT_LOG2 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_BLOCK    = 2'd2;

    typedef struct packed {
        logic [LOG2_W-1:0]  map_width_log2;
        logic [LOG2_W-1:0]  map_height_log2;
        logic [BLOCK_W-1:0] screen_block;
    } cfg_t;

    typedef struct packed {
        logic [COORD_W-1:0] tx;
        logic [COORD_W-1:0] ty;
        logic               is_column;
        logic               last;
    } cmd_t;

    typedef struct packed {
        logic busy;
        logic moves;
    } seq_stat_t;

    function automatic logic [LOG2_W-1:0] clamp_log2(input logic [LOG2_W-1:0] v);
        logic [LOG2_W-1:0] r;
        r = v;
        if (v < LOG2_MIN) begin
            r = LOG2_MIN;
        end else if (v > LOG2_MAX) begin
            r = LOG2_MAX;
        end
        return r;
    endfunction

endpackage

[rtl/tsea_addr_unit.sv]
// Shared address unit and output register: map index and ring offset per command.
// Depends on tsea_pkg.
`timescale 1ns / 1ps

module tsea_addr_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  tsea_pkg::cfg_t                cfg,
    input  logic                          cmd_valid,
    output logic                          cmd_ready,
    input  tsea_pkg::cmd_t                cmd,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [tsea_pkg::SRC_W-1:0]    m_src_index,
    output logic [tsea_pkg::DST_W-1:0]    m_dst_offset,
    output logic                          m_is_column,
    output logic                          m_last
);
    import tsea_pkg::*;

    logic               valid_reg;
    logic [SRC_W-1:0]   src_reg;
    logic [DST_W-1:0]   dst_reg;
    logic               col_reg;
    logic               last_reg;

    logic [COORD_W-1:0] mask_x;
    logic [COORD_W-1:0] mask_y;
    logic [SRC_W-1:0]   src_next;
    logic [11:0]        ring;
    logic [DST_W-1:0]   dst_next;
    logic               load;

    assign cmd_ready = !valid_reg || m_ready;
    assign load      = cmd_valid && cmd_ready;

    assign mask_x   = ~({COORD_W{1'b1}} << cfg.map_width_log2);
    assign mask_y   = ~({COORD_W{1'b1}} << cfg.map_height_log2);
    assign src_next = (SRC_W'(cmd.ty & mask_y) << cfg.map_width_log2)
                    | SRC_W'(cmd.tx & mask_x);

    // quadrant ring: bit 11 lower half, bit 10 right half, then row and column in block
    assign ring     = {cmd.ty[5], cmd.tx[5], cmd.ty[4:0], cmd.tx[4:0]};
    assign dst_next = DST_W'({cfg.screen_block, 10'b0}) + DST_W'(ring);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            if (load) begin
                valid_reg <= 1'b1;
                src_reg   <= src_next;
                dst_reg   <= dst_next;
                col_reg   <= cmd.is_column;
                last_reg  <= cmd.last;
            end else if (m_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid      = valid_reg;
    assign m_src_index  = src_reg;
    assign m_dst_offset = dst_reg;
    assign m_is_column  = col_reg;
    assign m_last       = last_reg;

endmodule

[rtl/tsea_seq.sv]
// Sequencer: compares camera position with the stored one and walks edge tiles.
// Depends on tsea_pkg.
`timescale 1ns / 1ps

module tsea_seq #(
    parameter int SCREEN_TILES_X = tsea_pkg::SCREEN_TILES_X_DEF,
    parameter int SCREEN_TILES_Y = tsea_pkg::SCREEN_TILES_Y_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [tsea_pkg::CAM_W-1:0]    s_cam_x,
    input  logic [tsea_pkg::CAM_W-1:0]    s_cam_y,
    output logic                          cmd_valid,
    input  logic                          cmd_ready,
    output tsea_pkg::cmd_t                cmd,
    output tsea_pkg::seq_stat_t           stat
);
    import tsea_pkg::*;

    localparam int ROW_CMDS = SCREEN_TILES_X + 1;
    localparam int COL_CMDS = SCREEN_TILES_Y + 3;
    localparam int MAX_CMDS = (ROW_CMDS > COL_CMDS) ? ROW_CMDS : COL_CMDS;
    localparam int CNT_W    = $clog2(MAX_CMDS);

    localparam logic [CNT_W-1:0]   ROW_LAST = CNT_W'(ROW_CMDS - 1);
    localparam logic [CNT_W-1:0]   COL_LAST = CNT_W'(COL_CMDS - 1);
    localparam logic [COORD_W-1:0] ROW_OFS  = COORD_W'(SCREEN_TILES_Y + 1);
    localparam logic [COORD_W-1:0] COL_OFS  = COORD_W'(SCREEN_TILES_X + 1);
    localparam logic [COORD_W-1:0] ONE      = COORD_W'(1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROW,
        ST_COL
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [COORD_W-1:0] x_reg, x_next;
    logic [COORD_W-1:0] y_reg, y_next;
    logic [COORD_W-1:0] col_tx_reg, col_tx_next;
    logic [COORD_W-1:0] col_ty_reg, col_ty_next;
    logic               col_pend_reg, col_pend_next;
    logic [CAM_W-1:0]   prev_x_reg, prev_x_next;
    logic [CAM_W-1:0]   prev_y_reg, prev_y_next;

    logic [COORD_W-1:0] tcx;
    logic [COORD_W-1:0] tcy;
    logic               moved_x;
    logic               moved_y;
    logic [COORD_W-1:0] row_ty;
    logic [COORD_W-1:0] col_tx;
    logic [COORD_W-1:0] step_in;
    logic [COORD_W-1:0] step_out;
    logic               accept;
    logic               fire;

    assign tcx     = s_cam_x[COORD_W+2:3];
    assign tcy     = s_cam_y[COORD_W+2:3];
    assign moved_x = s_cam_x != prev_x_reg;
    assign moved_y = s_cam_y != prev_y_reg;
    assign row_ty  = (s_cam_y < prev_y_reg) ? tcy - ONE : tcy + ROW_OFS;
    assign col_tx  = (s_cam_x < prev_x_reg) ? tcx - ONE : tcx + COL_OFS;

    assign s_ready   = state_reg == ST_IDLE;
    assign accept    = s_valid && s_ready;
    assign cmd_valid = state_reg != ST_IDLE;
    assign fire      = cmd_valid && cmd_ready;

    // one incrementer walks x along a row and y down a column
    assign step_in  = (state_reg == ST_ROW) ? x_reg : y_reg;
    assign step_out = step_in + ONE;

    always_comb begin
        cmd.tx        = x_reg;
        cmd.ty        = y_reg;
        cmd.is_column = state_reg == ST_COL;
        cmd.last      = 1'b0;
        case (state_reg)
            ST_ROW:  cmd.last = (cnt_reg == ROW_LAST) && !col_pend_reg;
            ST_COL:  cmd.last = cnt_reg == COL_LAST;
            default: cmd.last = 1'b0;
        endcase
    end

    assign stat.busy  = state_reg != ST_IDLE;
    assign stat.moves = moved_x || moved_y;

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        col_tx_next   = col_tx_reg;
        col_ty_next   = col_ty_reg;
        col_pend_next = col_pend_reg;
        prev_x_next   = prev_x_reg;
        prev_y_next   = prev_y_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    prev_x_next   = s_cam_x;
                    prev_y_next   = s_cam_y;
                    cnt_next      = '0;
                    col_tx_next   = col_tx;
                    col_ty_next   = tcy - ONE;
                    col_pend_next = moved_x;
                    if (moved_y) begin
                        state_next = ST_ROW;
                        x_next     = tcx;
                        y_next     = row_ty;
                    end else if (moved_x) begin
                        state_next = ST_COL;
                        x_next     = col_tx;
                        y_next     = tcy - ONE;
                    end
                end
            end
            ST_ROW: begin
                if (fire) begin
                    if (cnt_reg == ROW_LAST) begin
                        cnt_next = '0;
                        if (col_pend_reg) begin
                            state_next = ST_COL;
                            x_next     = col_tx_reg;
                            y_next     = col_ty_reg;
                        end else begin
                            state_next = ST_IDLE;
                        end
                    end else begin
                        cnt_next = cnt_reg + 1'b1;
                        x_next   = step_out;
                    end
                end
            end
            ST_COL: begin
                if (fire) begin
                    if (cnt_reg == COL_LAST) begin
                        cnt_next   = '0;
                        state_next = ST_IDLE;
                    end else begin
                        cnt_next = cnt_reg + 1'b1;
                        y_next   = step_out;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            prev_x_reg <= '0;
            prev_y_reg <= '0;
        end else begin
            state_reg    <= state_next;
            prev_x_reg   <= prev_x_next;
            prev_y_reg   <= prev_y_next;
            cnt_reg      <= cnt_next;
            x_reg        <= x_next;
            y_reg        <= y_next;
            col_tx_reg   <= col_tx_next;
            col_ty_reg   <= col_ty_next;
            col_pend_reg <= col_pend_next;
        end
    end

endmodule

[rtl/tilemap_scroll_edge_address_gen.sv]
// Channel   Handshake              Payload
// s_        s_valid / s_ready      s_cam_x, s_cam_y
// m_        m_valid / m_ready      m_src_index, m_dst_offset, m_is_column, m_last
// cfg_      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One copy command leaves per cycle while m_ready holds high; the sequencer feeds
// the shared address unit and its output register. A camera item with both axes moved
// yields SCREEN_TILES_X+1 row commands and SCREEN_TILES_Y+3 column commands (54 by default);
// an unmoved item yields no commands. s_ready is low while commands remain.
// A stall on m_ready holds the output register and the sequencer. Synchronous reset
// clears the stored camera position and restores the map registers; cfg_ready is always high.
// Top level of the scroll edge address generator; depends on tsea_pkg,
// tsea_seq, tsea_addr_unit and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tilemap_scroll_edge_address_gen #(
    parameter int SCREEN_TILES_X = tsea_pkg::SCREEN_TILES_X_DEF,
    parameter int SCREEN_TILES_Y = tsea_pkg::SCREEN_TILES_Y_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [tsea_pkg::CAM_W-1:0]        s_cam_x,
    input  logic [tsea_pkg::CAM_W-1:0]        s_cam_y,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [tsea_pkg::SRC_W-1:0]        m_src_index,
    output logic [tsea_pkg::DST_W-1:0]        m_dst_offset,
    output logic                              m_is_column,
    output logic                              m_last,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tsea_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tsea_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import tsea_pkg::*;

    logic [LOG2_W-1:0]  width_log2_reg;
    logic [LOG2_W-1:0]  height_log2_reg;
    logic [BLOCK_W-1:0] block_reg;

    cfg_t      cfg;
    cmd_t      cmd;
    seq_stat_t stat;
    logic      cmd_valid;
    logic      cmd_ready;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_log2_reg  <= WIDTH_LOG2_RST;
            height_log2_reg <= HEIGHT_LOG2_RST;
            block_reg       <= BLOCK_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_MAP_WIDTH_LOG2:  width_log2_reg  <= cfg_data[LOG2_W-1:0];
                REG_MAP_HEIGHT_LOG2: height_log2_reg <= cfg_data[LOG2_W-1:0];
                REG_SCREEN_BLOCK:    block_reg       <= cfg_data[BLOCK_W-1:0];
                default:             ;
            endcase
        end
    end

    assign cfg.map_width_log2  = clamp_log2(width_log2_reg);
    assign cfg.map_height_log2 = clamp_log2(height_log2_reg);
    assign cfg.screen_block    = block_reg;

    tsea_seq #(
        .SCREEN_TILES_X (SCREEN_TILES_X),
        .SCREEN_TILES_Y (SCREEN_TILES_Y)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_cam_x   (s_cam_x),
        .s_cam_y   (s_cam_y),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    tsea_addr_unit u_addr (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg),
        .cmd_valid    (cmd_valid),
        .cmd_ready    (cmd_ready),
        .cmd          (cmd),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_src_index  (m_src_index),
        .m_dst_offset (m_dst_offset),
        .m_is_column  (m_is_column),
        .m_last       (m_last)
    );

    `ASSERT_NEXT(a_move_starts_burst, s_valid && s_ready && stat.moves, stat.busy, "moved camera did not start a burst")
    `ASSERT_NEXT(a_still_stays_idle, s_valid && s_ready && !stat.moves, !stat.busy, "unmoved camera started a burst")
    `ASSERT_CLK(a_burst_continues, (m_valid && m_ready && !m_last) |-> stat.busy, "burst ended without last")
    `ASSERT_CLK(a_fill_from_seq, (!m_valid ##1 m_valid) |-> $past(cmd_valid), "output filled without a command")

endmodule
